// ===== src/mhfe_pkg.sv =====
package mhfe_pkg;

    // matcher phase per line
    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_SKIP    = 2'd1,
        PH_CAPTURE = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    // special characters
    localparam logic [7:0] NL_CHAR    = 8'd10;
    localparam logic [7:0] QUOTE_CHAR = 8'd34;
    localparam logic [7:0] SPACE_CHAR = 8'd32;
    localparam logic [7:0] ZERO_CHAR  = 8'd48;
    localparam logic [7:0] NINE_CHAR  = 8'd57;

    // pattern storage, last character in the low byte
    localparam int PAT_MAX_LEN = 15;
    typedef logic [8*PAT_MAX_LEN-1:0] pat_vec_t;

    localparam pat_vec_t   PAT_BOUNDARY = pat_vec_t'("boundary=");
    localparam logic [3:0] LEN_BOUNDARY = 4'd9;
    localparam pat_vec_t   PAT_FILENAME = pat_vec_t'("filename");
    localparam logic [3:0] LEN_FILENAME = 4'd8;
    localparam pat_vec_t   PAT_LENGTH   = pat_vec_t'("Content-Length:");
    localparam logic [3:0] LEN_LENGTH   = 4'd15;

    // bytes skipped after filename before capture
    localparam logic [3:0] FNAME_SKIP = 4'd2;

    localparam int         LEN_W   = 31;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    typedef struct packed {
        logic [3:0] pos;
        logic       hit;
    } match_res_t;

    // character p of a pattern of length len
    function automatic logic [7:0] pat_char(input pat_vec_t pat, input logic [3:0] len,
                                            input logic [3:0] p);
        logic [3:0] idx;
        idx = len - 4'd1 - p;
        return pat[8*idx +: 8];
    endfunction

    // one step of a border-free pattern matcher
    function automatic match_res_t match_step(input pat_vec_t pat, input logic [3:0] len,
                                              input logic [3:0] pos, input logic [7:0] c);
        logic [3:0] p;
        match_res_t r;
        p = (pos >= len) ? 4'd0 : pos;
        if (c == pat_char(pat, len, p)) begin
            p = p + 4'd1;
        end else begin
            p = (c == pat_char(pat, len, 4'd0)) ? 4'd1 : 4'd0;
        end
        if (p >= len) begin
            r.pos = 4'd0;
            r.hit = 1'b1;
        end else begin
            r.pos = p;
            r.hit = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== src/multipart_header_field_extractor_top.sv =====
// an accepted input word passes the input register, then the result register, before it shows on m_valid
// throughput: one input word per cycle while the result channel does not stall;
// matcher state updates as each word leaves the input register, so the per-byte
// matcher logic sets the rate; words that cause no result leave nothing on the result channel
// reset: synchronous active-low aresetn clears both registers' valid flags
// and all matcher state
module multipart_header_field_extractor_top (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_text_byte,
    input  logic                      s_final_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_char_out,
    output logic                      m_boundary_char,
    output logic                      m_filename_char,
    output logic                      m_boundary_end,
    output logic                      m_filename_end,
    output logic                      m_length_valid,
    output logic [mhfe_pkg::LEN_W-1:0] m_length_value
);
    import mhfe_pkg::*;

    // input register
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_final_reg;

    // matcher state
    logic [3:0]       b_pos_reg, b_pos_next;
    phase_t           b_phase_reg, b_phase_next;
    logic [3:0]       f_pos_reg, f_pos_next;
    phase_t           f_phase_reg, f_phase_next;
    logic [3:0]       l_pos_reg, l_pos_next;
    phase_t           l_phase_reg, l_phase_next;
    logic [LEN_W-1:0] acc_reg, acc_next;

    // result register
    logic             out_valid_reg;
    logic [7:0]       char_reg, char_next;
    logic             b_char_reg, b_char_next;
    logic             f_char_reg, f_char_next;
    logic             b_end_reg, b_end_next;
    logic             f_end_reg, f_end_next;
    logic             l_valid_reg, l_valid_next;
    logic [LEN_W-1:0] l_value_reg, l_value_next;

    logic             advance;
    logic             has_result;
    logic             is_nl;
    logic             line_end;
    logic             is_digit;
    match_res_t       b_match, f_match, l_match;
    logic [LEN_W+3:0] acc_mul;

    // handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign is_nl    = (in_byte_reg == NL_CHAR);
    assign line_end = is_nl || in_final_reg;
    assign is_digit = (in_byte_reg >= ZERO_CHAR) && (in_byte_reg <= NINE_CHAR);

    assign b_match = match_step(PAT_BOUNDARY, LEN_BOUNDARY, b_pos_reg, in_byte_reg);
    assign f_match = match_step(PAT_FILENAME, LEN_FILENAME, f_pos_reg, in_byte_reg);
    assign l_match = match_step(PAT_LENGTH, LEN_LENGTH, l_pos_reg, in_byte_reg);

    // acc * 10 + digit
    assign acc_mul = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                   + {{(LEN_W-4){1'b0}}, in_byte_reg - ZERO_CHAR};

    // matcher updates and result for the word in the input register
    always_comb begin
        b_pos_next   = b_pos_reg;
        b_phase_next = b_phase_reg;
        f_pos_next   = f_pos_reg;
        f_phase_next = f_phase_reg;
        l_pos_next   = l_pos_reg;
        l_phase_next = l_phase_reg;
        acc_next     = acc_reg;
        char_next    = 8'd0;
        b_char_next  = 1'b0;
        f_char_next  = 1'b0;
        b_end_next   = 1'b0;
        f_end_next   = 1'b0;
        l_valid_next = 1'b0;
        l_value_next = '0;

        if (!is_nl) begin
            // boundary
            case (b_phase_reg)
                PH_SEARCH: begin
                    b_pos_next = b_match.pos;
                    if (b_match.hit) begin
                        b_phase_next = PH_CAPTURE;
                    end
                end
                PH_CAPTURE: b_char_next = 1'b1;
                default: ;
            endcase

            // filename
            case (f_phase_reg)
                PH_SEARCH: begin
                    f_pos_next = f_match.pos;
                    if (f_match.hit) begin
                        f_phase_next = PH_SKIP;
                        f_pos_next   = 4'd0;
                    end
                end
                PH_SKIP: begin
                    f_pos_next = f_pos_reg + 4'd1;
                    if (f_pos_next >= FNAME_SKIP) begin
                        f_pos_next   = 4'd0;
                        f_phase_next = PH_CAPTURE;
                    end
                end
                PH_CAPTURE: begin
                    if (in_byte_reg == QUOTE_CHAR) begin
                        f_end_next   = 1'b1;
                        f_phase_next = PH_DONE;
                    end else begin
                        f_char_next = 1'b1;
                    end
                end
                default: ;
            endcase

            // content length
            case (l_phase_reg)
                PH_SEARCH: begin
                    l_pos_next = l_match.pos;
                    if (l_match.hit) begin
                        l_phase_next = PH_SKIP;
                        acc_next     = '0;
                    end
                end
                PH_SKIP, PH_CAPTURE: begin
                    if (is_digit) begin
                        acc_next     = (acc_mul > {4'd0, LEN_MAX}) ? LEN_MAX
                                                                   : acc_mul[LEN_W-1:0];
                        l_phase_next = PH_CAPTURE;
                    end else if (!(l_phase_reg == PH_SKIP && in_byte_reg == SPACE_CHAR)) begin
                        l_phase_next = PH_DONE;
                    end
                end
                default: ;
            endcase

            if (b_char_next || f_char_next) begin
                char_next = in_byte_reg;
            end
        end

        // end of line: report and clear
        if (line_end) begin
            if (b_phase_next == PH_CAPTURE) begin
                b_end_next = 1'b1;
            end
            if (f_phase_next == PH_SKIP || f_phase_next == PH_CAPTURE) begin
                f_end_next = 1'b1;
            end
            if (l_phase_next != PH_SEARCH) begin
                l_valid_next = 1'b1;
                l_value_next = acc_next;
            end
            b_pos_next   = 4'd0;
            b_phase_next = PH_SEARCH;
            f_pos_next   = 4'd0;
            f_phase_next = PH_SEARCH;
            l_pos_next   = 4'd0;
            l_phase_next = PH_SEARCH;
            acc_next     = '0;
        end
    end

    assign has_result = b_char_next || f_char_next || b_end_next || f_end_next
                      || l_valid_next;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_text_byte;
            in_final_reg <= s_final_byte;
        end
    end

    // matcher state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_pos_reg   <= 4'd0;
            b_phase_reg <= PH_SEARCH;
            f_pos_reg   <= 4'd0;
            f_phase_reg <= PH_SEARCH;
            l_pos_reg   <= 4'd0;
            l_phase_reg <= PH_SEARCH;
            acc_reg     <= '0;
        end else if (advance) begin
            b_pos_reg   <= b_pos_next;
            b_phase_reg <= b_phase_next;
            f_pos_reg   <= f_pos_next;
            f_phase_reg <= f_phase_next;
            l_pos_reg   <= l_pos_next;
            l_phase_reg <= l_phase_next;
            acc_reg     <= acc_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= has_result;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            char_reg    <= char_next;
            b_char_reg  <= b_char_next;
            f_char_reg  <= f_char_next;
            b_end_reg   <= b_end_next;
            f_end_reg   <= f_end_next;
            l_valid_reg <= l_valid_next;
            l_value_reg <= l_value_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_char_out      = char_reg;
    assign m_boundary_char = b_char_reg;
    assign m_filename_char = f_char_reg;
    assign m_boundary_end  = b_end_reg;
    assign m_filename_end  = f_end_reg;
    assign m_length_valid  = l_valid_reg;
    assign m_length_value  = l_value_reg;

endmodule

// ===== tb/sv/tb_multipart_header_field_extractor_top.sv =====
`timescale 1ns / 100ps

import mhfe_pkg::*;

// one word on the result channel
typedef struct packed {
    logic [7:0]       char_out;
    logic             boundary_char;
    logic             filename_char;
    logic             boundary_end;
    logic             filename_end;
    logic             length_valid;
    logic [LEN_W-1:0] length_value;
} field_word_t;

// header matcher prediction and result checking
class extract_scoreboard;
    int          mismatches;
    int          words_seen;
    field_word_t words_due[$];

    int               bnd_pos;
    int               fn_pos;
    int               len_pos;
    phase_t           bnd_ph;
    phase_t           fn_ph;
    phase_t           len_ph;
    logic [LEN_W-1:0] len_acc;

    function new();
        mismatches = 0;
        words_seen = 0;
        clear_line();
    endfunction

    function void clear_line();
        bnd_pos = 0;
        fn_pos  = 0;
        len_pos = 0;
        bnd_ph  = PH_SEARCH;
        fn_ph   = PH_SEARCH;
        len_ph  = PH_SEARCH;
        len_acc = '0;
    endfunction

    // next match position; equal to the pattern length on a hit
    function int next_pos(string pat, int pos, logic [7:0] c);
        int p;
        p = (pos >= pat.len()) ? 0 : pos;
        if (c == pat[p]) begin
            p++;
        end else begin
            p = (c == pat[0]) ? 1 : 0;
        end
        return p;
    endfunction

    // run one accepted text byte through the matchers
    function void note_byte(logic [7:0] c, logic fin);
        field_word_t w;
        int          p;
        longint      v;
        w = '0;
        if (c != NL_CHAR) begin
            // boundary value
            if (bnd_ph == PH_SEARCH) begin
                p = next_pos("boundary=", bnd_pos, c);
                if (p == 9) begin
                    bnd_pos = 0;
                    bnd_ph  = PH_CAPTURE;
                end else begin
                    bnd_pos = p;
                end
            end else if (bnd_ph == PH_CAPTURE) begin
                w.boundary_char = 1'b1;
            end

            // filename value, two bytes skipped after the name
            if (fn_ph == PH_SEARCH) begin
                p = next_pos("filename", fn_pos, c);
                if (p == 8) begin
                    fn_pos = 0;
                    fn_ph  = PH_SKIP;
                end else begin
                    fn_pos = p;
                end
            end else if (fn_ph == PH_SKIP) begin
                fn_pos++;
                if (fn_pos >= 2) begin
                    fn_pos = 0;
                    fn_ph  = PH_CAPTURE;
                end
            end else if (fn_ph == PH_CAPTURE) begin
                if (c == QUOTE_CHAR) begin
                    w.filename_end = 1'b1;
                    fn_ph          = PH_DONE;
                end else begin
                    w.filename_char = 1'b1;
                end
            end

            // content length digits, saturating
            if (len_ph == PH_SEARCH) begin
                p = next_pos("Content-Length:", len_pos, c);
                if (p == 15) begin
                    len_pos = 0;
                    len_ph  = PH_SKIP;
                    len_acc = '0;
                end else begin
                    len_pos = p;
                end
            end else if (len_ph == PH_SKIP || len_ph == PH_CAPTURE) begin
                if (c >= ZERO_CHAR && c <= NINE_CHAR) begin
                    v = longint'(len_acc) * 10 + (longint'(c) - longint'(ZERO_CHAR));
                    if (v > longint'(LEN_MAX)) v = longint'(LEN_MAX);
                    len_acc = v[LEN_W-1:0];
                    len_ph  = PH_CAPTURE;
                end else if (!(len_ph == PH_SKIP && c == SPACE_CHAR)) begin
                    len_ph = PH_DONE;
                end
            end

            if (w.boundary_char || w.filename_char) w.char_out = c;
        end

        // line close
        if (c == NL_CHAR || fin) begin
            if (bnd_ph == PH_CAPTURE) w.boundary_end = 1'b1;
            if (fn_ph == PH_SKIP || fn_ph == PH_CAPTURE) w.filename_end = 1'b1;
            if (len_ph != PH_SEARCH) begin
                w.length_valid = 1'b1;
                w.length_value = len_acc;
            end
            clear_line();
        end

        if (w.boundary_char || w.filename_char || w.boundary_end || w.filename_end ||
            w.length_valid) begin
            words_due.push_back(w);
        end
    endfunction

    task report(string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    task cmp(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report($sformatf("word %0d %s: got %0h, want %0h", words_seen, name, got, want));
        end
    endtask

    task check_word(field_word_t got);
        field_word_t want;
        words_seen++;
        if (words_due.size() == 0) begin
            report($sformatf("word %0d arrived with nothing due", words_seen));
            return;
        end
        want = words_due.pop_front();
        cmp("char_out", 32'(got.char_out), 32'(want.char_out));
        cmp("boundary_char", 32'(got.boundary_char), 32'(want.boundary_char));
        cmp("filename_char", 32'(got.filename_char), 32'(want.filename_char));
        cmp("boundary_end", 32'(got.boundary_end), 32'(want.boundary_end));
        cmp("filename_end", 32'(got.filename_end), 32'(want.filename_end));
        cmp("length_valid", 32'(got.length_valid), 32'(want.length_valid));
        cmp("length_value", 32'(got.length_value), 32'(want.length_value));
    endtask
endclass

module tb_multipart_header_field_extractor_top;

    // how a line is closed
    localparam int END_NEWLINE       = 0;
    localparam int END_NEWLINE_FINAL = 1;
    localparam int END_FINAL_TEXT    = 2;

    localparam int TEXT_BYTES     = 1800;
    localparam int WATCHDOG_LIMIT = 2000;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [7:0]       s_text_byte;
    logic             s_final_byte;
    logic             m_valid;
    logic             m_ready;
    logic [7:0]       m_char_out;
    logic             m_boundary_char;
    logic             m_filename_char;
    logic             m_boundary_end;
    logic             m_filename_end;
    logic             m_length_valid;
    logic [LEN_W-1:0] m_length_value;

    extract_scoreboard sb;
    logic [7:0]        line_bytes[$];
    int                bytes_sent  = 0;
    int                quiet_cycles = 0;
    bit                tx_fast     = 1'b0;
    string             near_miss[0:6] = '{"bound", "boundary", "file", "filenam",
                                          "Content-", "Content-Length", "content-length:"};

    multipart_header_field_extractor_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .s_final_byte   (s_final_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_char_out     (m_char_out),
        .m_boundary_char(m_boundary_char),
        .m_filename_char(m_filename_char),
        .m_boundary_end (m_boundary_end),
        .m_filename_end (m_filename_end),
        .m_length_valid (m_length_valid),
        .m_length_value (m_length_value)
    );

    // 50 MHz clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // line building
    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
    endfunction

    // random bytes that do not end the line
    function automatic void add_value(int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            do b = 8'($urandom_range(0, 255)); while (b == NL_CHAR);
            line_bytes.push_back(b);
        end
    endfunction

    function automatic void add_noise();
        int n;
        n = $urandom_range(0, 3);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: add_value($urandom_range(1, 4));
                1: add_text(near_miss[$urandom_range(0, 6)]);
                2: line_bytes.push_back(SPACE_CHAR);
                default: line_bytes.push_back(ZERO_CHAR + 8'($urandom_range(0, 9)));
            endcase
        end
    endfunction

    function automatic void add_boundary();
        add_text("boundary=");
        add_value($urandom_range(0, 8));
    endfunction

    function automatic void add_filename();
        add_text("filename");
        if ($urandom_range(0, 3) != 0) begin
            add_text("=\"");
        end else begin
            // odd skip bytes, quotes among them, or the line ends inside the skip
            repeat ($urandom_range(0, 2)) begin
                if ($urandom_range(0, 1) == 0) line_bytes.push_back(QUOTE_CHAR);
                else add_value(1);
            end
        end
        add_value($urandom_range(0, 8));
        if ($urandom_range(0, 2) != 0) line_bytes.push_back(QUOTE_CHAR);
    endfunction

    function automatic void add_length();
        int nd;
        add_text("Content-Length:");
        repeat ($urandom_range(0, 3)) line_bytes.push_back(SPACE_CHAR);
        // long digit runs drive the sum into saturation
        nd = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
        repeat (nd) line_bytes.push_back(ZERO_CHAR + 8'($urandom_range(0, 9)));
    endfunction

    // one text word through the handshake
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_text_byte  <= b;
        s_final_byte <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_line(input int style);
        int last;
        if (style != END_FINAL_TEXT || line_bytes.size() == 0) line_bytes.push_back(NL_CHAR);
        last    = line_bytes.size() - 1;
        tx_fast = ($urandom_range(0, 3) == 0);
        foreach (line_bytes[i]) send_byte(line_bytes[i], (style != END_NEWLINE) && (i == last));
        line_bytes.delete();
    endtask

    // hold the sender until every expected word is out
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.words_due.size() != 0) @(posedge aclk);
    endtask

    // sender and sequencing
    initial begin : stimulus
        int k;
        bit paused;
        paused = 1'b0;
        sb = new();
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_text_byte  <= '0;
        s_final_byte <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: byte extremes in a boundary, quoted name on a line closed by the final byte,
        // spaced length, empty line
        add_text("boundary=");
        line_bytes.push_back(8'hFF);
        line_bytes.push_back(8'h00);
        send_line(END_NEWLINE);
        add_text("filename=\"x\"z");
        send_line(END_FINAL_TEXT);
        add_text("Content-Length: 7");
        send_line(END_NEWLINE_FINAL);
        send_line(END_NEWLINE);
        drain_results();

        // random lines, mostly well formed
        while (bytes_sent < TEXT_BYTES) begin
            k = $urandom_range(0, 19);
            if ($urandom_range(0, 2) == 0) add_noise();
            if (k < 5) begin
                add_boundary();
            end else if (k < 10) begin
                add_filename();
            end else if (k < 15) begin
                add_length();
            end else if (k < 18) begin
                repeat ($urandom_range(2, 4)) begin
                    case ($urandom_range(0, 2))
                        0: add_boundary();
                        1: add_filename();
                        default: add_length();
                    endcase
                end
            end
            if ($urandom_range(0, 1) == 0) add_noise();
            send_line($urandom_range(END_NEWLINE, END_FINAL_TEXT));
            if (!paused && bytes_sent >= TEXT_BYTES / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("** multipart_header_field_extractor_top: PASSED **");
        end else begin
            $display("** multipart_header_field_extractor_top: FAILED **");
        end
        $finish;
    end

    // receiver with random stalls and unstalled stretches
    initial begin : receiver
        int hold;
        bit rx_fast;
        hold    = 0;
        rx_fast = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (m_ready && m_valid) begin
                if ($urandom_range(0, 31) == 0) rx_fast = !rx_fast;
                hold = rx_fast ? 0 : $urandom_range(0, 14);
                if (hold != 0) m_ready <= 1'b0;
            end else if (!m_ready) begin
                hold--;
                if (hold <= 0) m_ready <= 1'b1;
            end else if (!rx_fast && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 14);
                m_ready <= 1'b0;
            end
        end
    end

    // result word check
    always @(posedge aclk) begin : result_monitor
        field_word_t got;
        if (aresetn && m_valid && m_ready) begin
            got.char_out      = m_char_out;
            got.boundary_char = m_boundary_char;
            got.filename_char = m_filename_char;
            got.boundary_end  = m_boundary_end;
            got.filename_end  = m_filename_end;
            got.length_valid  = m_length_valid;
            got.length_value  = m_length_value;
            sb.check_word(got);
        end
    end

    // stall watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** multipart_header_field_extractor_top: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
